// ----- design/reciprocal_pair_matrix_store_macros.svh -----
// Assertion macros for the reciprocal pair matrix store.
// Used by modules that have i_clk and i_rst_n ports.
`ifndef RECIPROCAL_PAIR_MATRIX_STORE_MACROS_SVH
`define RECIPROCAL_PAIR_MATRIX_STORE_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define RPMS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rpms assertion failed");
// next-cycle implication
`define RPMS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rpms assertion failed");
`else
`define RPMS_ASSERT_IMP(lbl, ante, cons)
`define RPMS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- design/rpms_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and types for the reciprocal pair matrix store.
// No dependencies.
package rpms_pkg;

    localparam int MAX_DIM    = 16;
    localparam int PAIR_DEPTH = 120;

    localparam int DIM_W      = 5;
    localparam int IDX_W      = 4;
    localparam int VAL_W      = 24;
    localparam int STATUS_W   = 2;
    localparam int NODE_W     = $clog2(MAX_DIM);
    localparam int DEG_W      = $clog2(MAX_DIM);
    localparam int COV_W      = $clog2(MAX_DIM + 1);
    localparam int SLOT_W     = $clog2(PAIR_DEPTH);
    localparam int PAIR_CNT_W = $clog2(PAIR_DEPTH + 1);
    localparam int CALC_W     = 2 * DIM_W + 1;

    // reciprocal: round(2^32 / v); quotient of 2^33 / v for v above SAT_LIMIT
    localparam int QUOT_W     = VAL_W + 1;
    localparam int DIV_CNT_W  = $clog2(QUOT_W + 1);
    localparam logic [VAL_W-1:0] SAT_LIMIT = VAL_W'(256);
    localparam logic [VAL_W-1:0] REM_INIT  = VAL_W'(256);

    localparam logic [VAL_W-1:0] ONE_Q   = VAL_W'(65536);
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(4);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_DIAG  = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_RANGE = STATUS_W'(2);

    typedef struct packed {
        logic              deg_en;
        logic              deg_inc;
        logic [NODE_W-1:0] node;
        logic              pair_en;
        logic              pair_inc;
    } t_trk_op;

endpackage

// ----- design/rpms_recip.sv -----
`timescale 1ns / 1ps
// Bit-serial Q8.16 reciprocal: restoring radix-2 division, one quotient bit per cycle.
// Depends on rpms_pkg.
module rpms_recip (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rpms_pkg::VAL_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [rpms_pkg::VAL_W-1:0]  o_result
);
    import rpms_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0]     r_div;
    logic [VAL_W-1:0]     r_rem;
    logic [QUOT_W-1:0]    r_quo;

    logic [VAL_W:0]       rem_sh;
    logic [VAL_W:0]       diff;
    logic                 qbit;
    logic [VAL_W-1:0]     n_rem;
    logic [QUOT_W-1:0]    rnd;

    always_comb begin
        rem_sh = {r_rem, 1'b0};
        diff   = rem_sh - {1'b0, r_div};
        qbit   = rem_sh >= {1'b0, r_div};
        n_rem  = qbit ? diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
        // round half up; carry out means saturation
        rnd    = {1'b0, r_quo[QUOT_W-1:1]} + QUOT_W'(r_quo[0]);
    end

    assign o_done   = r_done;
    assign o_result = rnd[QUOT_W-1] ? VAL_MAX : rnd[VAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_div <= i_divisor;
                if (i_divisor == '0) begin
                    r_quo  <= '0;
                    r_done <= 1'b1;
                end else if (i_divisor <= SAT_LIMIT) begin
                    r_quo  <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= REM_INIT;
                    r_quo  <= '0;
                    r_cnt  <= DIV_CNT_W'(QUOT_W);
                    r_busy <= 1'b1;
                    r_done <= 1'b0;
                end
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quo  <= {r_quo[QUOT_W-2:0], qbit};
                r_cnt  <= r_cnt - DIV_CNT_W'(1);
                r_done <= r_cnt == DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

endmodule

// ----- design/rpms_store.sv -----
`timescale 1ns / 1ps
// Packed upper-triangle value memory with per-entry valid bits; invalid reads as zero.
// Depends on rpms_pkg.
module rpms_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic                        i_wr_en,
    input  logic [rpms_pkg::SLOT_W-1:0] i_wr_addr,
    input  logic [rpms_pkg::VAL_W-1:0]  i_wr_data,
    input  logic                        i_rd_en,
    input  logic [rpms_pkg::SLOT_W-1:0] i_rd_addr,
    output logic [rpms_pkg::VAL_W-1:0]  o_rd_data
);
    import rpms_pkg::*;

    logic [VAL_W-1:0]      r_mem [PAIR_DEPTH];
    logic [PAIR_DEPTH-1:0] r_valid;
    logic [VAL_W-1:0]      r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

endmodule

// ----- design/rpms_track.sv -----
`timescale 1ns / 1ps
// Per-node degree counters, covered-node count and nonzero-pair count.
// Depends on rpms_pkg.
module rpms_track (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_clear,
    input  rpms_pkg::t_trk_op               i_op,
    output logic [rpms_pkg::COV_W-1:0]      o_nodes_covered,
    output logic [rpms_pkg::PAIR_CNT_W-1:0] o_nonzero_pairs
);
    import rpms_pkg::*;

    logic [DEG_W-1:0]      r_deg [MAX_DIM];
    logic [COV_W-1:0]      r_covered;
    logic [PAIR_CNT_W-1:0] r_pairs;
    logic [DEG_W-1:0]      cur;

    assign cur             = r_deg[i_op.node];
    assign o_nodes_covered = r_covered;
    assign o_nonzero_pairs = r_pairs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < MAX_DIM; i++) begin
                r_deg[i] <= '0;
            end
            r_covered <= '0;
            r_pairs   <= '0;
        end else begin
            if (i_op.deg_en) begin
                if (i_op.deg_inc) begin
                    if (cur == '0) begin
                        r_covered <= r_covered + COV_W'(1);
                    end
                    r_deg[i_op.node] <= cur + DEG_W'(1);
                end else if (cur != '0) begin
                    r_deg[i_op.node] <= cur - DEG_W'(1);
                    if (cur == DEG_W'(1) && r_covered != '0) begin
                        r_covered <= r_covered - COV_W'(1);
                    end
                end
            end
            if (i_op.pair_en) begin
                if (i_op.pair_inc) begin
                    r_pairs <= r_pairs + PAIR_CNT_W'(1);
                end else if (r_pairs != '0) begin
                    r_pairs <= r_pairs - PAIR_CNT_W'(1);
                end
            end
        end
    end

endmodule

// ----- design/reciprocal_pair_matrix_store.sv -----
`timescale 1ns / 1ps
// Reciprocal pair matrix store, top level: command sequencer and output word register.
// Refused words and diagonal reads go from decode to done; reads above the diagonal add
// a fetch, writes a fetch, UPD and UPD2; below it the 25-step divider follows the fetch.
// One word in flight; the next is taken the cycle after the result is loaded.
// Synchronous active-low reset clears the store and counters and sets dimension to 4;
// a dimension write clears them the same way.
`include "reciprocal_pair_matrix_store_macros.svh"
module reciprocal_pair_matrix_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_dimension_we,
    input  logic [rpms_pkg::DIM_W-1:0]    i_dimension,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_command,
    input  logic [rpms_pkg::IDX_W-1:0]    i_row,
    input  logic [rpms_pkg::IDX_W-1:0]    i_col,
    input  logic [rpms_pkg::VAL_W-1:0]    i_write_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rpms_pkg::VAL_W-1:0]    o_read_value,
    output logic [rpms_pkg::STATUS_W-1:0] o_status,
    output logic                          o_all_known,
    output logic                          o_all_covered
);
    import rpms_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_DIV,
        S_UPD,
        S_UPD2,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [DIM_W-1:0]      r_dimension;
    logic                  r_cmd;
    logic                  r_upper;
    logic                  r_old_nz;
    logic [IDX_W-1:0]      r_row;
    logic [IDX_W-1:0]      r_col;
    logic [IDX_W-1:0]      r_lo;
    logic [IDX_W-1:0]      r_hi;
    logic [VAL_W-1:0]      r_val;
    logic [VAL_W-1:0]      r_nv;
    logic [VAL_W-1:0]      r_rd;
    logic [SLOT_W-1:0]     r_slot;
    logic [STATUS_W-1:0]   r_status;

    logic                  r_out_valid;
    logic [VAL_W-1:0]      r_read_value;
    logic [STATUS_W-1:0]   r_out_status;
    logic                  r_all_known;
    logic                  r_all_covered;

    logic [DIM_W-1:0]      dim_u;
    logic                  upper;
    logic [IDX_W-1:0]      lo;
    logic [IDX_W-1:0]      hi;
    logic [CALC_W-1:0]     slot_calc;
    logic [CALC_W-1:0]     pairs_needed;
    logic                  idx_bad;
    logic                  diag;
    logic                  slot_bad;
    logic                  changed;
    logic                  out_load;

    logic                  st_wr_en;
    logic                  st_rd_en;
    logic [VAL_W-1:0]      st_rd_data;
    logic                  div_start;
    logic [VAL_W-1:0]      div_in;
    logic                  div_done;
    logic [VAL_W-1:0]      div_res;
    t_trk_op               trk_op;
    logic [COV_W-1:0]      trk_covered;
    logic [PAIR_CNT_W-1:0] trk_pairs;

    always_comb begin
        if (int'(r_dimension) < 2) begin
            dim_u = DIM_W'(2);
        end else if (int'(r_dimension) > MAX_DIM) begin
            dim_u = DIM_W'(MAX_DIM);
        end else begin
            dim_u = r_dimension;
        end
        upper     = r_row < r_col;
        lo        = upper ? r_row : r_col;
        hi        = upper ? r_col : r_row;
        slot_calc = CALC_W'(lo) * CALC_W'(dim_u)
                  - ((CALC_W'(lo) * (CALC_W'(lo) + CALC_W'(1))) >> 1)
                  + CALC_W'(hi) - CALC_W'(lo) - CALC_W'(1);
        pairs_needed = (CALC_W'(dim_u) * (CALC_W'(dim_u) - CALC_W'(1))) >> 1;
        idx_bad   = DIM_W'(r_row) >= dim_u || DIM_W'(r_col) >= dim_u;
        diag      = r_row == r_col;
        slot_bad  = slot_calc >= CALC_W'(PAIR_DEPTH);
        changed   = r_old_nz != (|r_nv);
    end

    assign o_ready  = r_state == S_IDLE;
    assign out_load = r_state == S_DONE && (!r_out_valid || i_ready);

    assign st_wr_en  = r_state == S_UPD;
    assign st_rd_en  = r_state == S_DECODE && !idx_bad && !diag && !slot_bad;
    assign div_start = r_state == S_FETCH && !r_upper;
    assign div_in    = (r_cmd == CMD_READ) ? st_rd_data : r_val;

    always_comb begin
        trk_op = '0;
        if (r_state == S_UPD) begin
            trk_op.deg_en   = changed;
            trk_op.deg_inc  = !r_old_nz;
            trk_op.node     = NODE_W'(r_lo);
            trk_op.pair_en  = changed;
            trk_op.pair_inc = !r_old_nz;
        end else if (r_state == S_UPD2) begin
            trk_op.deg_en  = changed;
            trk_op.deg_inc = !r_old_nz;
            trk_op.node    = NODE_W'(r_hi);
        end
    end

    rpms_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (i_dimension_we),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (r_nv),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (slot_calc[SLOT_W-1:0]),
        .o_rd_data (st_rd_data)
    );

    rpms_recip u_recip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (div_in),
        .o_done    (div_done),
        .o_result  (div_res)
    );

    rpms_track u_track (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_clear         (i_dimension_we),
        .i_op            (trk_op),
        .o_nodes_covered (trk_covered),
        .o_nonzero_pairs (trk_pairs)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dimension <= DIM_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_dimension_we) begin
                r_dimension <= i_dimension;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd    <= i_command;
                        r_row    <= i_row;
                        r_col    <= i_col;
                        r_val    <= i_write_value;
                        r_rd     <= '0;
                        r_status <= ST_OK;
                        r_state  <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_lo    <= lo;
                    r_hi    <= hi;
                    r_upper <= upper;
                    r_slot  <= slot_calc[SLOT_W-1:0];
                    if (idx_bad) begin
                        r_status <= ST_RANGE;
                        r_state  <= S_DONE;
                    end else if (diag) begin
                        if (r_cmd == CMD_READ) begin
                            r_rd <= ONE_Q;
                        end else begin
                            r_status <= ST_DIAG;
                        end
                        r_state <= S_DONE;
                    end else if (slot_bad) begin
                        r_status <= ST_RANGE;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_old_nz <= |st_rd_data;
                    if (r_upper) begin
                        if (r_cmd == CMD_READ) begin
                            r_rd    <= st_rd_data;
                            r_state <= S_DONE;
                        end else begin
                            r_nv    <= r_val;
                            r_state <= S_UPD;
                        end
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_cmd == CMD_READ) begin
                            r_rd    <= div_res;
                            r_state <= S_DONE;
                        end else begin
                            r_nv    <= div_res;
                            r_state <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    r_state <= S_UPD2;
                end
                S_UPD2: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_read_value  <= r_rd;
                        r_out_status  <= r_status;
                        r_all_known   <= CALC_W'(trk_pairs) == pairs_needed;
                        r_all_covered <= CALC_W'(trk_covered) == CALC_W'(dim_u);
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_status      = r_out_status;
    assign o_all_known   = r_all_known;
    assign o_all_covered = r_all_covered;

    `RPMS_ASSERT_IMP(a_done_in_div, div_done, r_state == S_DIV)
    `RPMS_ASSERT_NXT(a_accept_blocks, i_valid && o_ready, !o_ready)
    `RPMS_ASSERT_IMP(a_store_wr_write, st_wr_en, r_cmd == CMD_WRITE && r_status == ST_OK)
    `RPMS_ASSERT_NXT(a_write_reads_zero, out_load && r_cmd == CMD_WRITE, o_read_value == '0)

endmodule

// ----- tb/tb_reciprocal_pair_matrix_store.sv -----
`timescale 1ns / 1ps
// Self-checking bench for reciprocal_pair_matrix_store: predicts every reply from its own
// copy of the packed triangle and counters. Depends on rpms_pkg and the design top level.
module tb_reciprocal_pair_matrix_store;
    import rpms_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0]    read_value;
        logic [STATUS_W-1:0] status;
        logic                all_known;
        logic                all_covered;
    } t_reply;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_dimension_we;
    logic [DIM_W-1:0]    i_dimension;
    logic                i_valid;
    logic                o_ready;
    logic                i_command;
    logic [IDX_W-1:0]    i_row;
    logic [IDX_W-1:0]    i_col;
    logic [VAL_W-1:0]    i_write_value;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [VAL_W-1:0]    o_read_value;
    logic [STATUS_W-1:0] o_status;
    logic                o_all_known;
    logic                o_all_covered;

    reciprocal_pair_matrix_store dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dimension_we (i_dimension_we),
        .i_dimension    (i_dimension),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_write_value  (i_write_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_read_value   (o_read_value),
        .o_status       (o_status),
        .o_all_known    (o_all_known),
        .o_all_covered  (o_all_covered)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the matrix store
    logic [VAL_W-1:0] pair_value [PAIR_DEPTH];
    int               node_links [MAX_DIM];
    int               covered_nodes;
    int               known_pairs;
    logic [DIM_W-1:0] cfg_dimension;

    t_reply pending_replies[$];

    bit bursts_on;
    int sink_hold;
    int fail_count;
    int sent_words;
    int random_words;
    int read_words;
    int write_words;
    int refused_words;
    int range_words;
    int dim_writes;
    int full_replies;
    int covered_replies;

    function automatic int used_dimension();
        if (cfg_dimension < 2) return 2;
        if (cfg_dimension > MAX_DIM) return MAX_DIM;
        return int'(cfg_dimension);
    endfunction

    function automatic void clear_matrix();
        for (int i = 0; i < PAIR_DEPTH; i++) pair_value[i] = '0;
        for (int i = 0; i < MAX_DIM; i++) node_links[i] = 0;
        covered_nodes = 0;
        known_pairs = 0;
    endfunction

    function automatic logic [VAL_W-1:0] reciprocal_q(logic [VAL_W-1:0] v);
        logic [63:0] q;
        if (v == '0) return '0;
        q = (((64'd1 << 33) / {40'd0, v}) + 64'd1) >> 1;
        if (q > {40'd0, VAL_MAX}) return VAL_MAX;
        return q[VAL_W-1:0];
    endfunction

    function automatic void raise_links(int n);
        if (node_links[n] == 0) covered_nodes++;
        node_links[n]++;
    endfunction

    function automatic void drop_links(int n);
        if (node_links[n] == 0) return;
        node_links[n]--;
        if (node_links[n] == 0 && covered_nodes > 0) covered_nodes--;
    endfunction

    function automatic t_reply matrix_access(logic cmd, logic [IDX_W-1:0] row,
                                             logic [IDX_W-1:0] col, logic [VAL_W-1:0] val);
        t_reply           r;
        int               dim;
        int               lo;
        int               hi;
        int               slot;
        logic [VAL_W-1:0] nv;
        dim = used_dimension();
        r.read_value = '0;
        r.status = ST_OK;
        if (cmd == CMD_READ) read_words++;
        else write_words++;
        if (row >= dim || col >= dim) begin
            r.status = ST_RANGE;
        end else if (row == col) begin
            if (cmd == CMD_READ) r.read_value = ONE_Q;
            else r.status = ST_DIAG;
        end else begin
            lo = (row < col) ? int'(row) : int'(col);
            hi = (row < col) ? int'(col) : int'(row);
            slot = lo * dim - (lo * (lo + 1)) / 2 + (hi - lo - 1);
            if (slot >= PAIR_DEPTH) begin
                r.status = ST_RANGE;
            end else if (cmd == CMD_READ) begin
                r.read_value = (row < col) ? pair_value[slot] : reciprocal_q(pair_value[slot]);
            end else begin
                nv = (row < col) ? val : reciprocal_q(val);
                if (pair_value[slot] != '0 && nv == '0) begin
                    drop_links(lo);
                    drop_links(hi);
                    if (known_pairs > 0) known_pairs--;
                end else if (pair_value[slot] == '0 && nv != '0) begin
                    raise_links(lo);
                    raise_links(hi);
                    known_pairs++;
                end
                pair_value[slot] = nv;
            end
        end
        if (r.status == ST_DIAG) refused_words++;
        if (r.status == ST_RANGE) range_words++;
        r.all_known = (known_pairs == (dim * (dim - 1)) / 2);
        r.all_covered = (covered_nodes == dim);
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] rand_ratio();
        case ($urandom_range(0, 5))
            0: return VAL_W'($urandom_range(1, 600));
            1: return VAL_W'(32'(ONE_Q) + $urandom_range(0, 4096) - 32'd2048);
            2: return VAL_MAX - VAL_W'($urandom_range(0, 300));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] rand_nonzero_ratio();
        logic [VAL_W-1:0] v;
        v = rand_ratio();
        if (v == '0) v = VAL_W'(1);
        return v;
    endfunction

    // sink side: random ready bursts
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            i_ready <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            sink_hold = $urandom_range(0, 14);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_replies.size() == 0) begin
                $error("reply word with no request outstanding");
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                if (o_read_value !== want.read_value) begin
                    $error("read_value: expected %h, actual %h", want.read_value, o_read_value);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_all_known !== want.all_known) begin
                    $error("all_known: expected %b, actual %b", want.all_known, o_all_known);
                    fail_count++;
                end
                if (o_all_covered !== want.all_covered) begin
                    $error("all_covered: expected %b, actual %b",
                           want.all_covered, o_all_covered);
                    fail_count++;
                end
                if (want.all_known) full_replies++;
                if (want.all_covered) covered_replies++;
            end
        end
    end

    task automatic send_word(input logic cmd, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] val);
        int gap;
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_row         <= row;
        i_col         <= col;
        i_write_value <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_replies.push_back(matrix_access(cmd, row, col, val));
        sent_words++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_dimension(input logic [DIM_W-1:0] raw);
        wait_idle();
        i_dimension_we <= 1'b1;
        i_dimension    <= raw;
        @(posedge i_clk);
        i_dimension_we <= 1'b0;
        cfg_dimension = raw;
        clear_matrix();
        dim_writes++;
    endtask

    task automatic fill_matrix(input int keep_pct);
        int dim;
        dim = used_dimension();
        for (int i = 0; i < dim; i++) begin
            for (int j = i + 1; j < dim; j++) begin
                if ($urandom_range(0, 99) < keep_pct) begin
                    if ($urandom_range(0, 1) == 0)
                        send_word(CMD_WRITE, IDX_W'(i), IDX_W'(j), rand_nonzero_ratio());
                    else
                        send_word(CMD_WRITE, IDX_W'(j), IDX_W'(i), rand_nonzero_ratio());
                end
            end
        end
    endtask

    task automatic random_access();
        int               dim;
        int               sel;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        logic [VAL_W-1:0] v;
        dim = used_dimension();
        sel = $urandom_range(0, 99);
        r = IDX_W'($urandom_range(0, dim - 1));
        c = IDX_W'($urandom_range(0, dim - 1));
        if (sel < 40) begin
            send_word(CMD_READ, r, c, VAL_W'($urandom));
        end else if (sel < 70) begin
            if (r == c) c = IDX_W'((int'(c) + 1) % dim);
            v = ($urandom_range(0, 99) < 15) ? '0 : rand_ratio();
            send_word(CMD_WRITE, r, c, v);
        end else if (sel < 78) begin
            send_word(CMD_WRITE, r, r, rand_ratio());
        end else begin
            send_word(1'($urandom), IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
        end
    endtask

    task automatic test_directed_access();
        send_word(CMD_READ,  4'd0,  4'd0,  VAL_W'(0));
        send_word(CMD_WRITE, 4'd1,  4'd1,  ONE_Q);
        send_word(CMD_READ,  4'd3,  4'd3,  VAL_MAX);
        send_word(CMD_WRITE, 4'd0,  4'd1,  VAL_W'(24'h020000));
        send_word(CMD_READ,  4'd0,  4'd1,  VAL_W'(0));
        send_word(CMD_READ,  4'd1,  4'd0,  VAL_W'(0));
        send_word(CMD_WRITE, 4'd2,  4'd1,  VAL_W'(1));
        send_word(CMD_READ,  4'd1,  4'd2,  VAL_W'(0));
        send_word(CMD_READ,  4'd2,  4'd1,  VAL_W'(0));
        send_word(CMD_WRITE, 4'd3,  4'd0,  VAL_MAX);
        send_word(CMD_WRITE, 4'd0,  4'd2,  VAL_W'(256));
        send_word(CMD_READ,  4'd2,  4'd0,  VAL_W'(0));
        send_word(CMD_WRITE, 4'd1,  4'd3,  VAL_W'(257));
        send_word(CMD_READ,  4'd3,  4'd1,  VAL_W'(0));
        send_word(CMD_WRITE, 4'd2,  4'd3,  ONE_Q);
        send_word(CMD_READ,  4'd4,  4'd0,  VAL_W'(0));
        send_word(CMD_WRITE, 4'd0,  4'd15, VAL_W'(1));
        send_word(CMD_WRITE, 4'd15, 4'd15, VAL_MAX);
        send_word(CMD_WRITE, 4'd0,  4'd1,  VAL_W'(0));
        send_word(CMD_READ,  4'd1,  4'd0,  VAL_W'(0));
        send_word(CMD_WRITE, 4'd1,  4'd0,  VAL_W'(0));
        send_word(CMD_WRITE, 4'd3,  4'd2,  VAL_W'(24'hAAAAAA));
        send_word(CMD_READ,  4'd2,  4'd3,  VAL_W'(24'h555555));
    endtask

    task automatic test_dimension_extremes();
        logic [DIM_W-1:0] raws [7];
        raws = '{DIM_W'(0), DIM_W'(1), DIM_W'(2), DIM_W'(16), DIM_W'(17), DIM_W'(31),
                 DIM_W'(4)};
        foreach (raws[k]) begin
            set_dimension(raws[k]);
            if (raws[k] <= 16) fill_matrix(100);
            else fill_matrix(20);
            repeat (12) random_access();
        end
    endtask

    task automatic test_random_traffic();
        int pick;
        int mix;
        while (random_words < 1250) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) set_dimension(DIM_W'($urandom_range(2, 6)));
            else if (pick < 58) set_dimension(DIM_W'(16));
            else if (pick < 78) set_dimension(DIM_W'($urandom_range(7, 15)));
            else if (pick < 86) set_dimension(DIM_W'($urandom_range(0, 1)));
            else set_dimension(DIM_W'($urandom_range(17, 31)));
            bursts_on = ($urandom_range(0, 3) != 0);
            mix = sent_words;
            if ($urandom_range(0, 9) < 8) fill_matrix(($urandom_range(0, 2) == 0) ? 70 : 100);
            repeat ($urandom_range(20, 60)) random_access();
            random_words += sent_words - mix;
        end
        bursts_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        set_dimension(DIM_W'(3));
        repeat (30) begin
            random_access();
            wait_idle();
        end
    endtask

    task automatic test_back_to_back();
        bursts_on = 1'b0;
        set_dimension(DIM_W'(5));
        fill_matrix(100);
        repeat (150) random_access();
        set_dimension(DIM_W'(16));
        repeat (100) random_access();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_dimension_we = 1'b0;
        i_dimension    = '0;
        i_valid        = 1'b0;
        i_command      = CMD_READ;
        i_row          = '0;
        i_col          = '0;
        i_write_value  = '0;
        bursts_on      = 1'b1;
        sink_hold      = 0;
        cfg_dimension  = DIM_RESET;
        clear_matrix();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_access();
        test_dimension_extremes();
        test_random_traffic();
        test_drain_pause();
        test_back_to_back();

        wait_idle();
        repeat (40) @(posedge i_clk);
        $display("covered %0d words (%0d reads, %0d writes; %0d diagonal refusals, %0d %s)",
                 sent_words, read_words, write_words, refused_words, range_words,
                 "out of range");
        $display("%0d dimension writes; %0d replies fully known, %0d fully covered",
                 dim_writes, full_replies, covered_replies);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
